FILE: hdl/dcdd_pkg.sv
// Shared types and constants of the decimal counter display driver.
package dcdd_pkg;

	localparam int ValueWidth = 16;
	localparam int MaxDigits  = 5;
	localparam int BcdDigits  = 5;
	localparam int BcdWidth   = 4 * BcdDigits;
	localparam int BitCountW  = $clog2(ValueWidth);
	localparam int CountWidth = 3;
	localparam int XWidth     = 11;
	localparam int AreaWidth  = 9;
	localparam int IndexWidth = 3;

	localparam logic [IndexWidth-1:0] CFG_ORIGIN_X      = 3'd0;
	localparam logic [IndexWidth-1:0] CFG_DIGIT_WIDTH   = 3'd1;
	localparam logic [IndexWidth-1:0] CFG_DIGIT_COUNT   = 3'd2;
	localparam logic [IndexWidth-1:0] CFG_ALWAYS_RED    = 3'd3;
	localparam logic [IndexWidth-1:0] CFG_PERCENT_MODE  = 3'd4;
	localparam logic [IndexWidth-1:0] CFG_PERCENT_GRAY  = 3'd5;
	localparam logic [IndexWidth-1:0] CFG_NEUTRAL_COLOR = 3'd6;

	localparam logic [ValueWidth-1:0]        SkipMagnitude = 16'd1994;
	localparam logic signed [ValueWidth-1:0] NegLimitTwo   = -16'sd9;
	localparam logic signed [ValueWidth-1:0] NegLimitThree = -16'sd99;
	localparam logic [ValueWidth-1:0]        MagLimitTwo   = 16'd9;
	localparam logic [ValueWidth-1:0]        MagLimitThree = 16'd99;

	typedef enum logic [1:0] {
		CMD_CLEAR   = 2'd0,
		CMD_DIGIT   = 2'd1,
		CMD_MINUS   = 2'd2,
		CMD_PERCENT = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [9:0] origin_x;
		logic [5:0] digit_width;
		logic       always_red;
		logic       percent_mode;
		logic       percent_gray;
	} cfg_t;

	typedef struct packed {
		logic [ValueWidth-1:0] mag;
		logic                  neg;
		logic                  tr;
		logic [CountWidth-1:0] cnt;
		logic                  skip;
	} job_t;

endpackage

FILE: hdl/dcdd_bcd.sv
// Bit-serial binary to decimal converter using the shift-and-add-three method.
module dcdd_bcd (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [dcdd_pkg::ValueWidth-1:0] bin,
	output logic                            done,
	output logic [dcdd_pkg::BcdWidth-1:0]   bcd
);

	logic [dcdd_pkg::ValueWidth-1:0] bin_q;
	logic [dcdd_pkg::BcdWidth-1:0]   bcd_q;
	logic [dcdd_pkg::BcdWidth-1:0]   adj;
	logic [dcdd_pkg::BitCountW-1:0]  cnt_q;
	logic                            busy_q;
	logic                            done_q;

	always_comb begin
		for (int i = 0; i < dcdd_pkg::BcdDigits; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
			bin_q  <= bin;
			bcd_q  <= '0;
		end else if (busy_q) begin
			bcd_q <= {adj[dcdd_pkg::BcdWidth-2:0], bin_q[dcdd_pkg::ValueWidth-1]};
			bin_q <= {bin_q[dcdd_pkg::ValueWidth-2:0], 1'b0};
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == dcdd_pkg::BitCountW'(dcdd_pkg::ValueWidth - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

FILE: hdl/dcdd_emit.sv
// Command sequencer with output register for one redraw of the number field.
module dcdd_emit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  dcdd_pkg::job_t                      job,
	input  dcdd_pkg::cfg_t                      cfg,
	output logic                                busy,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [1:0]                          command,
	output logic signed [dcdd_pkg::XWidth-1:0]  x_pos,
	output logic [dcdd_pkg::AreaWidth-1:0]      area_width,
	output logic [3:0]                          digit,
	output logic                                translate,
	output logic                                use_gray,
	output logic                                last
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CONV,
		S_PCT,
		S_CLR,
		S_DIG,
		S_MINUS
	} state_t;

	state_t                               state_q;
	dcdd_pkg::job_t                       job_q;
	logic [dcdd_pkg::AreaWidth-1:0]       area_q;
	logic [dcdd_pkg::BcdWidth-1:0]        digits_q;
	logic signed [dcdd_pkg::XWidth-1:0]   x_q;
	logic [dcdd_pkg::CountWidth-1:0]      left_q;
	logic                                 out_valid_q;
	dcdd_pkg::cmd_t                       cmd_q;
	logic signed [dcdd_pkg::XWidth-1:0]   xo_q;
	logic [dcdd_pkg::AreaWidth-1:0]       aw_q;
	logic [3:0]                           dig_q;
	logic                                 tr_q;
	logic                                 gray_q;
	logic                                 last_q;

	logic                                 bcd_done;
	logic [dcdd_pkg::BcdWidth-1:0]        bcd_value;
	logic [dcdd_pkg::AreaWidth-1:0]       area;
	logic signed [dcdd_pkg::XWidth-1:0]   origin;
	logic signed [dcdd_pkg::XWidth-1:0]   w_ext;
	logic signed [dcdd_pkg::XWidth-1:0]   x_next;
	logic                                 room;
	logic                                 fire;
	logic                                 dig_done;

	dcdd_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.bin    (job.mag),
		.done   (bcd_done),
		.bcd    (bcd_value)
	);

	assign area     = dcdd_pkg::AreaWidth'(job.cnt) * dcdd_pkg::AreaWidth'(cfg.digit_width);
	assign origin   = {1'b0, cfg.origin_x};
	assign w_ext    = {5'b0, cfg.digit_width};
	assign x_next   = x_q - w_ext;
	assign room     = !out_valid_q || out_ready;
	assign fire     = room && (state_q inside {S_PCT, S_CLR, S_DIG, S_MINUS});
	assign dig_done = (digits_q[dcdd_pkg::BcdWidth-1:4] == '0) || (left_q == 3'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						job_q   <= job;
						area_q  <= area;
						state_q <= S_CONV;
					end
				end
				S_CONV: begin
					if (bcd_done) begin
						digits_q <= bcd_value;
						x_q      <= origin;
						left_q   <= job_q.cnt;
						state_q  <= cfg.percent_mode ? S_PCT : S_CLR;
					end
				end
				S_PCT: begin
					if (room) begin
						cmd_q       <= dcdd_pkg::CMD_PERCENT;
						xo_q        <= origin;
						aw_q        <= '0;
						dig_q       <= '0;
						tr_q        <= !cfg.always_red;
						gray_q      <= cfg.percent_gray;
						last_q      <= 1'b0;
						state_q     <= S_CLR;
					end
				end
				S_CLR: begin
					if (room) begin
						cmd_q       <= dcdd_pkg::CMD_CLEAR;
						xo_q        <= origin - {2'b0, area_q};
						aw_q        <= area_q;
						dig_q       <= '0;
						tr_q        <= 1'b0;
						gray_q      <= 1'b0;
						last_q      <= job_q.skip;
						state_q     <= job_q.skip ? S_IDLE : S_DIG;
					end
				end
				S_DIG: begin
					if (room) begin
						cmd_q       <= dcdd_pkg::CMD_DIGIT;
						xo_q        <= x_next;
						aw_q        <= '0;
						dig_q       <= digits_q[3:0];
						tr_q        <= job_q.tr;
						gray_q      <= 1'b0;
						last_q      <= dig_done && !job_q.neg;
						x_q         <= x_next;
						digits_q    <= {4'b0, digits_q[dcdd_pkg::BcdWidth-1:4]};
						left_q      <= left_q - 1'b1;
						if (dig_done) begin
							state_q <= job_q.neg ? S_MINUS : S_IDLE;
						end
					end
				end
				S_MINUS: begin
					if (room) begin
						cmd_q       <= dcdd_pkg::CMD_MINUS;
						xo_q        <= x_next;
						aw_q        <= '0;
						dig_q       <= '0;
						tr_q        <= job_q.tr;
						gray_q      <= 1'b0;
						last_q      <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign out_valid  = out_valid_q;
	assign command    = cmd_q;
	assign x_pos      = xo_q;
	assign area_width = aw_q;
	assign digit      = dig_q;
	assign translate  = tr_q;
	assign use_gray   = gray_q;
	assign last       = last_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == S_IDLE)
		else $error("A redraw was started while the sequencer was busy.");

	a_digits_left: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIG |-> left_q != '0)
		else $error("Digit emission continued with no digit positions left.");

	a_minus_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MINUS && room) |=> (state_q == S_IDLE && out_valid_q && last_q))
		else $error("The minus sign did not close the redraw.");

endmodule

FILE: hdl/decimal_counter_display_driver_core.sv
// Top level of the decimal counter display driver: registers, input stage and sequencer.
//
//   Channel  Signals                                         Direction
//   cfg      cfg_valid, cfg_ready, cfg_index, cfg_data        in
//   in       in_valid, in_ready, value, color_code, ...       in
//   out      out_valid, out_ready, command, x_pos, ...        out
//
// An input transaction that causes no redraw ends when it is accepted.
// After acceptance a redraw runs a bit-serial binary to decimal conversion, then issues
// its commands into the output register: between 1 and 8 commands.
// The input stays stalled until the last command is in the output register; a stalled
// output holds the sequencer. Reset sets the configuration registers to their default
// values and the last shown value to zero; the configuration port is always ready.
module decimal_counter_display_driver_core (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       cfg_valid,
	output logic                                       cfg_ready,
	input  logic [dcdd_pkg::IndexWidth-1:0]            cfg_index,
	input  logic [9:0]                                 cfg_data,
	input  logic                                       in_valid,
	output logic                                       in_ready,
	input  logic signed [dcdd_pkg::ValueWidth-1:0]     value,
	input  logic [3:0]                                 color_code,
	input  logic                                       refresh,
	input  logic                                       enabled,
	output logic                                       out_valid,
	input  logic                                       out_ready,
	output logic [1:0]                                 command,
	output logic signed [dcdd_pkg::XWidth-1:0]         x_pos,
	output logic [dcdd_pkg::AreaWidth-1:0]             area_width,
	output logic [3:0]                                 digit,
	output logic                                       translate,
	output logic                                       use_gray,
	output logic                                       last
);

	logic [9:0]                              origin_x_q;
	logic [5:0]                              digit_width_q;
	logic [2:0]                              digit_count_q;
	logic                                    always_red_q;
	logic                                    percent_mode_q;
	logic                                    percent_gray_q;
	logic [3:0]                              neutral_color_q;
	logic signed [dcdd_pkg::ValueWidth-1:0]  last_value_q;

	logic                                    busy;
	logic                                    accept;
	logic                                    redraw;
	logic                                    start;
	logic [dcdd_pkg::CountWidth-1:0]         cnt;
	logic signed [dcdd_pkg::ValueWidth:0]    neg_value;
	dcdd_pkg::job_t                          job;
	dcdd_pkg::cfg_t                          cfg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q      <= '0;
			digit_width_q   <= 6'd14;
			digit_count_q   <= 3'd3;
			always_red_q    <= 1'b0;
			percent_mode_q  <= 1'b0;
			percent_gray_q  <= 1'b0;
			neutral_color_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				dcdd_pkg::CFG_ORIGIN_X:      origin_x_q      <= cfg_data;
				dcdd_pkg::CFG_DIGIT_WIDTH:   digit_width_q   <= cfg_data[5:0];
				dcdd_pkg::CFG_DIGIT_COUNT:   digit_count_q   <= cfg_data[2:0];
				dcdd_pkg::CFG_ALWAYS_RED:    always_red_q    <= cfg_data[0];
				dcdd_pkg::CFG_PERCENT_MODE:  percent_mode_q  <= cfg_data[0];
				dcdd_pkg::CFG_PERCENT_GRAY:  percent_gray_q  <= cfg_data[0];
				dcdd_pkg::CFG_NEUTRAL_COLOR: neutral_color_q <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign in_ready  = !busy;
	assign accept    = in_valid && in_ready;
	assign redraw    = enabled && (value != last_value_q || refresh);
	assign start     = accept && redraw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_value_q <= '0;
		end else if (start) begin
			last_value_q <= value;
		end
	end

	always_comb begin
		if (digit_count_q == 3'd0) begin
			cnt = 3'd1;
		end else if (digit_count_q > dcdd_pkg::CountWidth'(dcdd_pkg::MaxDigits)) begin
			cnt = dcdd_pkg::CountWidth'(dcdd_pkg::MaxDigits);
		end else begin
			cnt = digit_count_q;
		end
		neg_value = -{value[dcdd_pkg::ValueWidth-1], value};
		job.neg   = value[dcdd_pkg::ValueWidth-1];
		job.cnt   = cnt;
		job.tr    = (color_code != neutral_color_q) && !always_red_q;
		if (job.neg && cnt == 3'd2 && value < dcdd_pkg::NegLimitTwo) begin
			job.mag = dcdd_pkg::MagLimitTwo;
		end else if (job.neg && cnt == 3'd3 && value < dcdd_pkg::NegLimitThree) begin
			job.mag = dcdd_pkg::MagLimitThree;
		end else if (job.neg) begin
			job.mag = neg_value[dcdd_pkg::ValueWidth-1:0];
		end else begin
			job.mag = value;
		end
		job.skip = (job.mag == dcdd_pkg::SkipMagnitude);
	end

	assign cfg.origin_x     = origin_x_q;
	assign cfg.digit_width  = digit_width_q;
	assign cfg.always_red   = always_red_q;
	assign cfg.percent_mode = percent_mode_q;
	assign cfg.percent_gray = percent_gray_q;

	dcdd_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.job        (job),
		.cfg        (cfg),
		.busy       (busy),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.command    (command),
		.x_pos      (x_pos),
		.area_width (area_width),
		.digit      (digit),
		.translate  (translate),
		.use_gray   (use_gray),
		.last       (last)
	);

endmodule
